/* design/lsb_first_bit_packer_macros.svh */
// ----------------------------------------------------------------------------
// LSB-first bit packer assertion macros
// Shared assertion forms for the checker. Each use sits on a line of its own.
// ----------------------------------------------------------------------------
`ifndef LSB_FIRST_BIT_PACKER_MACROS_SVH
`define LSB_FIRST_BIT_PACKER_MACROS_SVH

// Clocked property, off while reset is asserted.
`define LBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that also holds during reset.
`define LBP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* design/lbp_pkg.sv */
// ----------------------------------------------------------------------------
// LSB-first bit packer package
// Op codes, register map, queue sizing and the front-to-back control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

    typedef enum logic [1:0] {
        OP_BITS  = 2'd0,
        OP_BYTE  = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    // Register index is paddr[2]
    localparam logic REG_OUT_CAPACITY = 1'b0;
    localparam logic [31:0] CAP_RESET = 32'd65536;

    // At most 8 bytes per item for fields up to 64 bits
    localparam int NB_W   = 4;
    localparam int IDX_W  = 3;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic [NB_W-1:0] nbytes;  // bytes to emit, zero means one empty result
        logic            status;  // full flag after the item
    } item_ctl_t;

endpackage

`default_nettype wire

/* design/lbp_front.sv */
// ----------------------------------------------------------------------------
// LSB-first bit packer front end
// Accepts items, appends bits to the pending byte, applies the capacity limit
// and hands the bytes to emit for each item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_front
    import lbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 64
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   accept,
    input  wire logic [1:0]                             op,
    input  wire logic [MAX_FIELD_BITS-1:0]              bit_value,
    input  wire logic [$clog2(MAX_FIELD_BITS+1)-1:0]    bit_count,
    input  wire logic [7:0]                             byte_value,
    input  wire logic                                   cfg_wr,
    input  wire logic [31:0]                            cfg_data,
    output item_ctl_t                                   push_ctl,
    output logic [((MAX_FIELD_BITS+7)/8)*8-1:0]         push_data
);

    localparam int MAXB   = (MAX_FIELD_BITS + 7) / 8;
    localparam int DATA_W = MAXB * 8;
    localparam int CNT_W  = $clog2(MAX_FIELD_BITS + 1);
    localparam int WORD_W = DATA_W + 8;
    localparam logic [NB_W-1:0] ROOM_SAT = NB_W'(MAXB + 1);

    logic [6:0]        pend_bits_reg, pend_bits_next;
    logic [2:0]        pend_cnt_reg, pend_cnt_next;
    logic              full_reg, full_next;
    logic [32:0]       room_reg, room_next;   // capacity minus bytes written
    logic [31:0]       bw_reg, bw_next;

    logic [MAX_FIELD_BITS-1:0] val_mask;
    logic [WORD_W-1:0]         word;
    logic [WORD_W-1:0]         word_rest;
    logic [CNT_W:0]            total;
    logic [NB_W-1:0]           bits_nb;
    logic                      count_ok;
    logic                      room_pos;
    logic [NB_W-1:0]           room_clip;
    logic [NB_W-1:0]           nb;
    logic [NB_W-1:0]           emit_n;
    logic                      drop;
    logic                      full_new;
    logic [DATA_W-1:0]         data;
    logic [6:0]                keep_bits;
    logic [2:0]                keep_cnt;

    always_comb
    begin
        val_mask  = bit_value & ~({MAX_FIELD_BITS{1'b1}} << bit_count);
        word      = ({{(WORD_W-MAX_FIELD_BITS){1'b0}}, val_mask} << pend_cnt_reg)
                  | {{(WORD_W-7){1'b0}}, pend_bits_reg};
        total     = {{(CNT_W-2){1'b0}}, pend_cnt_reg} + {1'b0, bit_count};
        bits_nb   = NB_W'(total >> 3);
        word_rest = word >> {bits_nb, 3'b000};
        count_ok  = (bit_count <= CNT_W'(MAX_FIELD_BITS));

        case (op)
            OP_BITS:
            begin
                if (count_ok)
                begin
                    nb        = bits_nb;
                    data      = word[DATA_W-1:0];
                    keep_bits = word_rest[6:0];
                    keep_cnt  = total[2:0];
                end
                else
                begin
                    nb        = '0;
                    data      = '0;
                    keep_bits = pend_bits_reg;
                    keep_cnt  = pend_cnt_reg;
                end
            end
            OP_BYTE:
            begin
                nb        = NB_W'(1);
                data      = {{(DATA_W-8){1'b0}}, byte_value};
                keep_bits = '0;
                keep_cnt  = '0;
            end
            OP_FLUSH:
            begin
                nb        = (pend_cnt_reg != '0) ? NB_W'(1) : '0;
                data      = {{(DATA_W-7){1'b0}}, pend_bits_reg};
                keep_bits = '0;
                keep_cnt  = '0;
            end
            default:
            begin
                nb        = '0;
                data      = '0;
                keep_bits = pend_bits_reg;
                keep_cnt  = pend_cnt_reg;
            end
        endcase

        // Room left, saturated just above the most bytes one item can hold
        room_pos = !room_reg[32] && (room_reg != '0);
        if (full_reg || !room_pos)
            room_clip = '0;
        else if (room_reg > 33'(MAXB))
            room_clip = ROOM_SAT;
        else
            room_clip = room_reg[NB_W-1:0];

        drop     = (nb > room_clip);
        emit_n   = drop ? room_clip : nb;
        full_new = full_reg | ((nb != '0) && (nb >= room_clip));

        push_ctl.nbytes = emit_n;
        push_ctl.status = full_new;
        push_data       = data;

        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        full_next      = full_reg;
        room_next      = room_reg;
        bw_next        = bw_reg;

        if (cfg_wr)
        begin
            room_next = {1'b0, cfg_data} - {1'b0, bw_reg};
        end
        else if (accept)
        begin
            // Drop the pending bits along with the rest of an item that overflows
            pend_bits_next = drop ? 7'd0 : keep_bits;
            pend_cnt_next  = drop ? 3'd0 : keep_cnt;
            full_next      = full_new;
            room_next      = room_reg - {{(33-NB_W){1'b0}}, emit_n};
            bw_next        = bw_reg + {{(32-NB_W){1'b0}}, emit_n};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            full_reg      <= 1'b0;
            room_reg      <= {1'b0, CAP_RESET};
            bw_reg        <= '0;
        end
        else
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            full_reg      <= full_next;
            room_reg      <= room_next;
            bw_reg        <= bw_next;
        end
    end

endmodule

`default_nettype wire

/* design/lbp_queue.sv */
// ----------------------------------------------------------------------------
// LSB-first bit packer item queue
// Short first-in first-out buffer of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_queue
    import lbp_pkg::*;
#(
    parameter int DATA_W = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  item_ctl_t              push_ctl,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output item_ctl_t              head_ctl,
    output logic [DATA_W-1:0]      head_data,
    output logic                   full,
    output logic                   empty
);

    item_ctl_t         ctl_mem  [QDEPTH];
    logic [DATA_W-1:0] data_mem [QDEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    always_comb
    begin
        full      = (count_reg == (QPTR_W+1)'(QDEPTH));
        empty     = (count_reg == '0);
        head_ctl  = ctl_mem[rd_ptr_reg];
        head_data = data_mem[rd_ptr_reg];

        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg]  <= push_ctl;
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/lbp_back.sv */
// ----------------------------------------------------------------------------
// LSB-first bit packer back end
// Unrolls each queued item into one result per byte, or a single empty
// result, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_back
    import lbp_pkg::*;
#(
    parameter int DATA_W = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  item_ctl_t              head_ctl,
    input  wire logic [DATA_W-1:0] head_data,
    input  wire logic              q_empty,
    output logic                   pop,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic [7:0]             out_byte,
    output logic                   byte_valid,
    output logic                   status,
    output logic                   last
);

    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             bv_reg, bv_next;
    logic             status_reg, status_next;
    logic             last_reg, last_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic              advance;
    logic              final_byte;
    logic [DATA_W-1:0] data_sel;

    always_comb
    begin
        advance    = !valid_reg || !out_stall;
        data_sel   = head_data >> {idx_reg, 3'b000};
        final_byte = ({1'b0, idx_reg} == (head_ctl.nbytes - NB_W'(1)));

        valid_next  = valid_reg;
        byte_next   = byte_reg;
        bv_next     = bv_reg;
        status_next = status_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        pop         = 1'b0;

        if (advance)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                status_next = head_ctl.status;
                if (head_ctl.nbytes == '0)
                begin
                    byte_next = 8'd0;
                    bv_next   = 1'b0;
                    last_next = 1'b1;
                    pop       = 1'b1;
                end
                else
                begin
                    byte_next = data_sel[7:0];
                    bv_next   = 1'b1;
                    last_next = final_byte;
                    pop       = final_byte;
                    // Advance to the next byte, or rewind for the next item
                    idx_next  = final_byte ? '0 : idx_reg + 1'b1;
                end
            end
        end

        out_valid  = valid_reg;
        out_byte   = byte_reg;
        byte_valid = bv_reg;
        status     = status_reg;
        last       = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        bv_reg     <= bv_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire

/* design/lsb_first_bit_packer.sv */
// ----------------------------------------------------------------------------
// LSB-first bit packer
// Packs variable-length bit fields least significant bit first into bytes,
// with raw byte writes, flush to a byte boundary and an output capacity.
// ----------------------------------------------------------------------------
// The front end accepts one item per clock while the four-entry item queue has
// room, and does all bit merging and capacity accounting in that cycle. The
// back end drains the queue one result per clock while out_stall is low: an
// item gives one result per byte it emits, and one empty result when it emits
// none (up to eight bytes for a 64-bit field on a part-filled byte). The output
// byte port therefore sets the sustained rate; an item's first result passes
// through the queue and the registered output stage. status reports the full
// flag as it stands after the item, on every result of that item. out_capacity
// is at byte address 0 and should be written only while no item is in flight.
`default_nettype none

module lsb_first_bit_packer
    import lbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 64
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          op,
    input  wire logic [MAX_FIELD_BITS-1:0]           bit_value,
    input  wire logic [$clog2(MAX_FIELD_BITS+1)-1:0] bit_count,
    input  wire logic [7:0]                          byte_value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [7:0]                               out_byte,
    output logic                                     byte_valid,
    output logic                                     status,
    output logic                                     last,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    localparam int DATA_W = ((MAX_FIELD_BITS + 7) / 8) * 8;

    logic [31:0]       cap_reg, cap_next;
    logic              cfg_wr;
    logic              accept;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    item_ctl_t         push_ctl;
    item_ctl_t         head_ctl;
    logic [DATA_W-1:0] push_data;
    logic [DATA_W-1:0] head_data;

    always_comb
    begin
        pready   = 1'b1;
        cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_OUT_CAPACITY);
        cap_next = cfg_wr ? pwdata : cap_reg;
        prdata   = (paddr[2] == REG_OUT_CAPACITY) ? cap_reg : 32'd0;
        in_stall = q_full;
        accept   = in_valid && !q_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else
            cap_reg <= cap_next;
    end

    lbp_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (op),
        .bit_value  (bit_value),
        .bit_count  (bit_count),
        .byte_value (byte_value),
        .cfg_wr     (cfg_wr),
        .cfg_data   (pwdata),
        .push_ctl   (push_ctl),
        .push_data  (push_data)
    );

    lbp_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_ctl  (push_ctl),
        .push_data (push_data),
        .pop       (pop),
        .head_ctl  (head_ctl),
        .head_data (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    lbp_back #(
        .DATA_W (DATA_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_ctl   (head_ctl),
        .head_data  (head_data),
        .q_empty    (q_empty),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .status     (status),
        .last       (last)
    );

endmodule

`default_nettype wire

/* design/lbp_checker.sv */
// ----------------------------------------------------------------------------
// LSB-first bit packer port checker
// Watches the result port over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lsb_first_bit_packer_macros.svh"

module lbp_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       byte_valid,
    input wire logic       status,
    input wire logic       last
);

    // Handshake: a stalled result stays put
    `LBP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last), "stalled result changed")

    // An empty result is zero and closes its item
    `LBP_ASSERT(a_empty_result, out_valid && !byte_valid |-> out_byte == 8'd0 && last, "empty result not zero or not last")

    // Full is sticky until reset
    `LBP_ASSERT(a_status_sticky, out_valid && status && !out_stall |=> !out_valid || status, "status fell without reset")

    // No results and no stall come out of reset
    `LBP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid && !in_stall, "activity during reset")

endmodule

bind lsb_first_bit_packer lbp_checker u_lbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .status     (status),
    .last       (last)
);

`default_nettype wire
